/* rtl/core/ufta_pkg.sv */
package ufta_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned EvW     = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_TIMEOUT  = 2'd0,
    CFG_FULL_TIMEOUT  = 2'd1,
    CFG_CHECK_INTERVAL = 2'd2
  } cfg_idx_t;

  typedef enum logic [EvW-1:0] {
    EV_DELETED   = 2'd0,
    EV_CREATED   = 2'd1,
    EV_PROCESSED = 2'd2,
    EV_TABLE_FULL = 2'd3
  } event_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic match;
    logic rev;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic due;
    logic udp;
    logic scan_last;
    logic hit;
    logic free;
  } sts_t;

  typedef struct packed {
    logic [EvW-1:0] ev;
    logic [31:0]    sip;
    logic [15:0]    sp;
    logic [31:0]    dip;
    logic [15:0]    dp;
    logic           full;
    logic [31:0]    tm;
  } res_t;

endpackage

/* rtl/core/udp_flow_table_with_aging.sv */
// UDP flow table with idle aging.
// Input: raise start with the packet fields while busy is low; the packet
// is taken on that edge and busy stays high until all its results are out.
// Config: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 half timeout, 1 full timeout, 2 check interval); other indexes are
// dropped. Write only while busy is low.
// Results: each result is shown for one cycle with out_valid; the receiver
// cannot stall. out_last marks the final result of a packet. A packet that
// causes no result just returns busy low.
// Sequence: one result is staged before it leaves. A packet passes through
// the check and flush states; UDP work adds a match state, and a new flow
// also a reverse lookup state. When the check interval has elapsed, an aging
// scan visits every entry before the lookup, one entry per cycle.
// Key lookups compare all entries in parallel.
// Reset clears all valid bits, the last scan time and loads the default
// register values.
module udp_flow_table_with_aging #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_is_udp,
  input  logic [31:0]                  in_src_ip,
  input  logic [15:0]                  in_src_port,
  input  logic [31:0]                  in_dst_ip,
  input  logic [15:0]                  in_dst_port,
  input  logic [31:0]                  in_time_sec,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ufta_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                  cfg_data,
  output logic                         out_valid,
  output logic [ufta_pkg::EvW-1:0]     out_event_res,
  output logic [31:0]                  out_flow_src_ip,
  output logic [15:0]                  out_flow_src_port,
  output logic [31:0]                  out_flow_dst_ip,
  output logic [15:0]                  out_flow_dst_port,
  output logic                         out_flow_full,
  output logic [31:0]                  out_flow_time,
  output logic                         out_last
);
  import ufta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ufta_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ufta_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_is_udp         (in_is_udp),
    .in_src_ip         (in_src_ip),
    .in_src_port       (in_src_port),
    .in_dst_ip         (in_dst_ip),
    .in_dst_port       (in_dst_port),
    .in_time_sec       (in_time_sec),
    .out_valid         (out_valid),
    .out_event_res     (out_event_res),
    .out_flow_src_ip   (out_flow_src_ip),
    .out_flow_src_port (out_flow_src_port),
    .out_flow_dst_ip   (out_flow_dst_ip),
    .out_flow_dst_port (out_flow_dst_port),
    .out_flow_full     (out_flow_full),
    .out_flow_time     (out_flow_time),
    .out_last          (out_last)
  );

endmodule

/* rtl/core/ufta_ctrl.sv */
module ufta_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ufta_pkg::sts_t sts,
  output ufta_pkg::cmd_t cmd,
  output logic          busy
);
  import ufta_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_MATCH = 6'b001000,
    S_REV   = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.due)      state_nxt = S_SCAN;
        else if (sts.udp) state_nxt = S_MATCH;
        else              state_nxt = S_FLUSH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = sts.udp ? S_MATCH : S_FLUSH;
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = (sts.hit || !sts.free) ? S_FLUSH : S_REV;
      end
      S_REV: begin
        cmd.rev   = 1'b1;
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/ufta_dp.sv */
module ufta_dp #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ufta_pkg::cmd_t                    cmd,
  output ufta_pkg::sts_t                    sts,
  input  logic                              cfg_valid,
  input  logic [ufta_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_is_udp,
  input  logic [31:0]                       in_src_ip,
  input  logic [15:0]                       in_src_port,
  input  logic [31:0]                       in_dst_ip,
  input  logic [15:0]                       in_dst_port,
  input  logic [31:0]                       in_time_sec,
  output logic                              out_valid,
  output logic [ufta_pkg::EvW-1:0]          out_event_res,
  output logic [31:0]                       out_flow_src_ip,
  output logic [15:0]                       out_flow_src_port,
  output logic [31:0]                       out_flow_dst_ip,
  output logic [15:0]                       out_flow_dst_port,
  output logic                              out_flow_full,
  output logic [31:0]                       out_flow_time,
  output logic                              out_last
);
  import ufta_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);

  logic [31:0] half_to_r, full_to_r, chk_int_r;
  logic [TIME_BITS-1:0] last_chk_r;

  logic                 udp_r;
  logic [31:0]          sip_r, dip_r;
  logic [15:0]          sp_r, dp_r;
  logic [TIME_BITS-1:0] now_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [31:0]            e_sip [TABLE_DEPTH];
  logic [15:0]            e_sp  [TABLE_DEPTH];
  logic [31:0]            e_dip [TABLE_DEPTH];
  logic [15:0]            e_dp  [TABLE_DEPTH];
  logic                   e_full[TABLE_DEPTH];
  logic [TIME_BITS-1:0]   e_time[TABLE_DEPTH];

  logic [IW-1:0] idx_r, slot_r;

  logic          pend_v_r;
  res_t          pend_r;

  // lookup lanes
  logic [TABLE_DEPTH-1:0] fwd_m, rev_m;
  logic [IW-1:0] hit_idx, free_idx, rev_idx;
  logic hit, free, rev_hit;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      fwd_m[i] = valid_r[i] && e_sip[i] == sip_r && e_sp[i] == sp_r &&
                 e_dip[i] == dip_r && e_dp[i] == dp_r;
      rev_m[i] = valid_r[i] && e_sip[i] == dip_r && e_sp[i] == dp_r &&
                 e_dip[i] == sip_r && e_dp[i] == sp_r;
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    rev_idx  = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (fwd_m[i])    hit_idx  = IW'(i);
      if (!valid_r[i]) free_idx = IW'(i);
      if (rev_m[i])    rev_idx  = IW'(i);
    end
  end

  assign hit     = |fwd_m;
  assign free    = ~&valid_r;
  assign rev_hit = |rev_m;

  logic [TIME_BITS-1:0] since_chk, idle;
  logic [31:0]          limit;
  logic                 due, expire;

  assign since_chk = now_r - last_chk_r;
  assign due       = (chk_int_r != '0) && (CW'(since_chk) >= CW'(chk_int_r));
  assign idle      = now_r - e_time[idx_r];
  assign limit     = e_full[idx_r] ? full_to_r : half_to_r;
  assign expire    = valid_r[idx_r] && (CW'(idle) >= CW'(limit));

  assign sts.due       = due;
  assign sts.udp       = udp_r;
  assign sts.scan_last = (idx_r == LastIdx);
  assign sts.hit       = hit;
  assign sts.free      = free;

  // result staging
  logic push;
  res_t push_d;

  always_comb begin
    push   = 1'b0;
    push_d = '{ev: EV_PROCESSED, sip: sip_r, sp: sp_r, dip: dip_r, dp: dp_r,
               full: 1'b0, tm: 32'(now_r)};
    if (cmd.scan) begin
      push   = expire;
      push_d = '{ev: EV_DELETED, sip: e_sip[idx_r], sp: e_sp[idx_r],
                 dip: e_dip[idx_r], dp: e_dp[idx_r], full: e_full[idx_r],
                 tm: 32'(e_time[idx_r])};
    end else if (cmd.match) begin
      push = 1'b1;
      if (hit) begin
        push_d.ev   = EV_PROCESSED;
        push_d.full = e_full[hit_idx];
      end else if (free) begin
        push_d.ev = EV_CREATED;
      end else begin
        push_d.ev = EV_TABLE_FULL;
      end
    end else if (cmd.rev) begin
      push        = 1'b1;
      push_d.ev   = EV_PROCESSED;
      push_d.full = rev_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_to_r  <= 32'd60;
      full_to_r  <= 32'd180;
      chk_int_r  <= 32'd1;
      last_chk_r <= '0;
      valid_r    <= '0;
      pend_v_r   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_HALF_TIMEOUT:   half_to_r <= cfg_data;
          CFG_FULL_TIMEOUT:   full_to_r <= cfg_data;
          CFG_CHECK_INTERVAL: chk_int_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.scan) begin
        if (expire) valid_r[idx_r] <= 1'b0;
        if (idx_r == LastIdx) last_chk_r <= now_r;
      end
      if (cmd.match && !hit && free) valid_r[free_idx] <= 1'b1;
      // hold one result back so the final one can carry last
      if (push) begin
        pend_v_r <= 1'b1;
        if (pend_v_r) out_valid <= 1'b1;
      end
      if (cmd.flush) begin
        pend_v_r <= 1'b0;
        if (pend_v_r) out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      udp_r <= in_is_udp;
      sip_r <= in_src_ip;
      sp_r  <= in_src_port;
      dip_r <= in_dst_ip;
      dp_r  <= in_dst_port;
      now_r <= TIME_BITS'(in_time_sec);
    end
    if (cmd.check) idx_r <= '0;
    else if (cmd.scan) idx_r <= idx_r + IW'(1);
    if (cmd.match) begin
      slot_r <= free_idx;
      if (hit) begin
        e_time[hit_idx] <= now_r;
      end else if (free) begin
        e_sip[free_idx]  <= sip_r;
        e_sp[free_idx]   <= sp_r;
        e_dip[free_idx]  <= dip_r;
        e_dp[free_idx]   <= dp_r;
        e_full[free_idx] <= 1'b0;
        e_time[free_idx] <= now_r;
      end
    end
    if (cmd.rev && rev_hit) begin
      e_full[slot_r]  <= 1'b1;
      e_full[rev_idx] <= 1'b1;
    end
    if (push) pend_r <= push_d;
    if ((push || cmd.flush) && pend_v_r) begin
      out_event_res     <= pend_r.ev;
      out_flow_src_ip   <= pend_r.sip;
      out_flow_src_port <= pend_r.sp;
      out_flow_dst_ip   <= pend_r.dip;
      out_flow_dst_port <= pend_r.dp;
      out_flow_full     <= pend_r.full;
      out_flow_time     <= pend_r.tm;
      out_last          <= cmd.flush;
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ufta_pkg::*;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam logic [1:0]  CFG_SPARE  = 2'd3;  // no register behind this index

  class flow_scoreboard;
    logic [31:0] half_to, full_to, chk_int, last_scan;
    bit          slot_used[DEPTH];
    res_t        slot[DEPTH];
    res_t        expected_q[$];
    bit          last_q[$];
    int          errors;

    function new();
      half_to   = 32'd60;
      full_to   = 32'd180;
      chk_int   = 32'd1;
      last_scan = '0;
      errors    = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        CFG_HALF_TIMEOUT:   half_to = v;
        CFG_FULL_TIMEOUT:   full_to = v;
        CFG_CHECK_INTERVAL: chk_int = v;
        default: ;
      endcase
    endfunction

    function int lookup(logic [31:0] sip, logic [15:0] sp, logic [31:0] dip,
                        logic [15:0] dp);
      for (int i = 0; i < DEPTH; i++)
        if (slot_used[i] && slot[i].sip == sip && slot[i].sp == sp &&
            slot[i].dip == dip && slot[i].dp == dp) return i;
      return -1;
    endfunction

    function void push(res_t r, event_t ev);
      r.ev = ev;
      expected_q.push_back(r);
      last_q.push_back(1'b0);
    endfunction

    function void note_packet(bit udp, logic [31:0] sip, logic [15:0] sp,
                              logic [31:0] dip, logic [15:0] dp, logic [31:0] now);
      int   n0, hit, free_slot, rev;
      res_t r;
      logic [31:0] limit;
      n0 = expected_q.size();
      if (chk_int != 0 && (now - last_scan) >= chk_int) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!slot_used[i]) continue;
          limit = slot[i].full ? full_to : half_to;
          if ((now - slot[i].tm) >= limit) begin
            push(slot[i], EV_DELETED);
            slot_used[i] = 1'b0;
          end
        end
        last_scan = now;
      end
      if (udp) begin
        hit = lookup(sip, sp, dip, dp);
        if (hit >= 0) begin
          slot[hit].tm = now;
          push(slot[hit], EV_PROCESSED);
        end else begin
          free_slot = -1;
          for (int i = DEPTH - 1; i >= 0; i--) if (!slot_used[i]) free_slot = i;
          r = '{ev: EV_TABLE_FULL, sip: sip, sp: sp, dip: dip, dp: dp, full: 1'b0, tm: now};
          if (free_slot < 0) begin
            push(r, EV_TABLE_FULL);
          end else begin
            slot_used[free_slot] = 1'b1;
            slot[free_slot] = r;
            push(r, EV_CREATED);
            rev = lookup(dip, dp, sip, sp);
            if (rev >= 0) begin
              slot[free_slot].full = 1'b1;
              slot[rev].full = 1'b1;
            end
            push(slot[free_slot], EV_PROCESSED);
          end
        end
      end
      if (expected_q.size() > n0) last_q[$] = 1'b1;
    endfunction

    function void report(string what);
      $display("mismatch @%0t: %s", $time, what);
      errors++;
    endfunction

    function void check_result(res_t got, bit got_last);
      res_t want;
      bit   want_last;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result ev=%0d", got.ev));
        return;
      end
      want = expected_q.pop_front();
      want_last = last_q.pop_front();
      if (got != want || got_last != want_last)
        report($sformatf("got ev%0d %h:%h->%h:%h f%0d t%h l%0d, want ev%0d %h:%h->%h:%h f%0d t%h l%0d",
          got.ev, got.sip, got.sp, got.dip, got.dp, got.full, got.tm, got_last,
          want.ev, want.sip, want.sp, want.dip, want.dp, want.full, want.tm, want_last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_is_udp = 1'b0;
  logic [31:0] in_src_ip = '0, in_dst_ip = '0, in_time_sec = '0;
  logic [15:0] in_src_port = '0, in_dst_port = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        out_valid, out_flow_full, out_last;
  logic [1:0]  out_event_res;
  logic [31:0] out_flow_src_ip, out_flow_dst_ip, out_flow_time;
  logic [15:0] out_flow_src_port, out_flow_dst_port;

  flow_scoreboard sb = new();
  int unsigned cycles = 0;
  int          sender_idle = 0;
  logic [31:0] clock_sec = '0;
  logic [31:0] pool_ip[12];
  logic [15:0] pool_port[12];

  always #5 clk = ~clk;

  udp_flow_table_with_aging i_dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL udp_flow_table_with_aging");
      $finish;
    end
    if (rst_n && out_valid)
      sb.check_result('{ev: out_event_res, sip: out_flow_src_ip, sp: out_flow_src_port,
                        dip: out_flow_dst_ip, dp: out_flow_dst_port,
                        full: out_flow_full, tm: out_flow_time}, out_last);
  end

  task automatic send_packet(bit udp, logic [31:0] sip, logic [15:0] sp,
                             logic [31:0] dip, logic [15:0] dp, logic [31:0] t);
    while ($urandom_range(99) < sender_idle) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_is_udp = udp;
    in_src_ip = sip;
    in_src_port = sp;
    in_dst_ip = dip;
    in_dst_port = dp;
    in_time_sec = t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_packet(udp, sip, sp, dip, dp, t);
    @(negedge clk);
    start = 1'b0;
  endtask

  // hold until the table is quiet, covering packets that give no result
  task automatic drain();
    while (sb.expected_q.size() != 0 || busy) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_packet();
    int a, b;
    bit udp;
    logic [31:0] sip, dip;
    logic [15:0] sp, dp;
    a = $urandom_range(11);
    b = $urandom_range(11);
    udp = $urandom_range(99) < 90;
    if ($urandom_range(99) < 12) begin
      sip = $urandom; dip = $urandom; sp = 16'($urandom); dp = 16'($urandom);
    end else begin
      sip = pool_ip[a]; sp = pool_port[a]; dip = pool_ip[b]; dp = pool_port[b];
    end
    if ($urandom_range(99) < 3) clock_sec = $urandom;
    else clock_sec = clock_sec + $urandom_range(0, 25);
    send_packet(udp, sip, sp, dip, dp, clock_sec);
  endtask

  initial begin
    foreach (pool_ip[i]) begin
      pool_ip[i] = $urandom;
      pool_port[i] = 16'($urandom);
    end
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: non-UDP, create, reverse, hit, self-reverse, extreme keys, aging
    send_packet(1'b0, 32'h0a000001, 16'd53, 32'h0a000002, 16'd5353, 32'd0);
    send_packet(1'b1, 32'h0a000001, 16'd53, 32'h0a000002, 16'd5353, 32'd5);
    send_packet(1'b1, 32'h0a000002, 16'd5353, 32'h0a000001, 16'd53, 32'd6);
    send_packet(1'b1, 32'h0a000001, 16'd53, 32'h0a000002, 16'd5353, 32'd7);
    send_packet(1'b1, 32'hc0a80101, 16'd9, 32'hc0a80101, 16'd9, 32'd8);
    send_packet(1'b1, '1, '1, '1, '1, 32'd9);
    send_packet(1'b1, '0, '0, '0, '0, 32'd10);
    send_packet(1'b1, '0, '0, '1, '1, 32'd70);
    send_packet(1'b0, '1, '1, '0, '0, 32'd200);
    drain();

    // fill the table with aging off, overflow it, then flush across a time wrap
    write_cfg(CFG_CHECK_INTERVAL, 32'd0);
    for (int i = 0; i < DEPTH + 2; i++)
      send_packet(1'b1, 32'h01000000 + i, 16'(i), 32'h02000000, 16'd80, 32'hfffffff0);
    drain();
    write_cfg(CFG_HALF_TIMEOUT, 32'd0);
    write_cfg(CFG_FULL_TIMEOUT, 32'd0);
    write_cfg(CFG_CHECK_INTERVAL, 32'd1);
    write_cfg(CFG_SPARE, 32'hffffffff);
    send_packet(1'b1, 32'h03000000, 16'd1, 32'h04000000, 16'd2, 32'd3);
    drain();

    write_cfg(CFG_HALF_TIMEOUT, 32'd30);
    write_cfg(CFG_FULL_TIMEOUT, 32'd90);
    write_cfg(CFG_CHECK_INTERVAL, 32'd5);
    sender_idle = 37;
    for (int i = 0; i < 59; i++) begin
      random_packet();
      if (i == 40) begin
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
    end
    drain();

    write_cfg(CFG_HALF_TIMEOUT, 32'hffffffff);
    write_cfg(CFG_FULL_TIMEOUT, 32'd0);
    write_cfg(CFG_CHECK_INTERVAL, 32'hffffffff);
    sender_idle = 53;
    for (int i = 0; i < 59; i++) random_packet();
    drain();

    write_cfg(CFG_HALF_TIMEOUT, 32'd20);
    write_cfg(CFG_FULL_TIMEOUT, 32'd50);
    write_cfg(CFG_CHECK_INTERVAL, 32'd1);
    sender_idle = 0;
    for (int i = 0; i < 58; i++) random_packet();
    drain();

    if (sb.errors == 0) $display("PASS udp_flow_table_with_aging");
    else $display("FAIL udp_flow_table_with_aging");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/ufta_pkg.sv
rtl/core/ufta_ctrl.sv
rtl/core/ufta_dp.sv
rtl/core/udp_flow_table_with_aging.sv
tb/tb_top.sv
